FILE: src/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants of the sliding-window average core
// Field widths, reset values and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int AVG_W     = 24;
  localparam int WLEN_W    = 9;
  localparam int FRAC_W    = 8;
  localparam int DEPTH_DEF = 256;

  localparam logic [WLEN_W-1:0] WLEN_RST = 9'd256;

  // Commands from the controller to the datapath, at most one per cycle.
  typedef struct packed {
    logic accept;  // latch the sample and read the oldest entry
    logic update;  // write the ring, update sum, count and write slot
    logic load;    // load the divider with |sum| * 256
    logic step;    // one restoring division step
    logic finish;  // load the output register
  } swa_cmd_t;

  typedef struct packed {
    logic div_last;  // the current division step is the last one
  } swa_sts_t;

endpackage

FILE: src/sliding_window_average_core.sv
// ----------------------------------------------------------------------------
// sliding_window_average_core: moving average over a configurable window
// Top level joining the sequencing controller and the window datapath.
// ----------------------------------------------------------------------------
// Usage notes:
// Each request on the in_ stream carries one signed 16-bit sample. The core
// keeps the most recent samples, up to the configured window length, and
// after each push returns one result on the out_ stream: the mean of the held
// samples in signed Q15.8, truncated toward zero, with tuser set once the
// window is full. The mean is reported before the window fills as well.
// The cfg_ channel writes the window length (1 to 256 for the default ring;
// zero acts as one, larger values saturate to the ring size). A write clears
// the window and must only happen while the core is idle. cfg_ready is high.
// A request is accepted only once the previous one has left the restoring
// divider, which produces one quotient bit per cycle over SUM_W + 8 bits.
// A finished result sits in an output register, so the next sample is
// accepted while it waits. If the receiver stalls, the following result is
// held inside until the register frees, and in_tready stays low.
// Reset empties the window and sets the window length to 256.
module sliding_window_average_core #(
  parameter int DEPTH = swa_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write channel, data is the window length.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swa_pkg::WLEN_W-1:0]   cfg_data,
  // Sample stream. tdata: sample [15:0].
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [swa_pkg::SAMPLE_W-1:0] in_tdata,
  // Result stream. tdata: average [23:0]. tuser: window_full [0].
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swa_pkg::AVG_W-1:0]    out_tdata,
  output logic [0:0]                   out_tuser
);
  import swa_pkg::*;

  swa_cmd_t cmd;
  swa_sts_t sts;
  logic     cfg_we;
  logic     full;

  // Writes must only be issued while idle; the block does not enforce this, and cfg_ready is tied high.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_tuser = full;

  swa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swa_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wlen    (cfg_data),
    .sample      (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .average     (out_tdata),
    .window_full (full)
  );

endmodule

FILE: src/swa_ctrl.sv
// ----------------------------------------------------------------------------
// swa_ctrl: sequencing state machine
// Walks each request through accept, update, divider load, division steps
// and result hand-off, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module swa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  swa_pkg::swa_sts_t sts,
  output swa_pkg::swa_cmd_t cmd
);
  import swa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UPD  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // The previous result must be gone or leaving before this one lands.
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result loaded over a result not yet taken");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("loaded result not presented");

  a_step_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.step)
    else $error("divider loaded but not stepped");

endmodule

FILE: src/swa_dpath.sv
// ----------------------------------------------------------------------------
// swa_dpath: sample ring, running sum, count and restoring divider
// Holds the window state and the window length register, and computes
// sum * 256 / count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swa_dpath #(
  parameter int DEPTH = swa_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [swa_pkg::WLEN_W-1:0]    cfg_wlen,
  input  logic [swa_pkg::SAMPLE_W-1:0]  sample,
  input  swa_pkg::swa_cmd_t             cmd,
  output swa_pkg::swa_sts_t             sts,
  output logic [swa_pkg::AVG_W-1:0]     average,
  output logic                          window_full
);
  import swa_pkg::*;

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH);
  localparam int D_W    = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(D_W);

  logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];

  logic [WLEN_W-1:0]          wlen_r;
  logic [AW-1:0]              ws_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] samp_r, rd_r;
  logic                       drop_r, full_r, neg_r;
  logic [D_W-1:0]             dvd_r;
  logic [CNT_W-1:0]           rem_r;
  logic [STEP_W-1:0]          step_r;
  logic [AVG_W-1:0]           avg_r;
  logic                       full_out_r;

  logic [CNT_W-1:0] len;
  logic             drop;
  logic [CNT_W:0]   old_tmp;
  logic [AW-1:0]    old_addr;
  logic [SUM_W-1:0] mag;
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [AVG_W-1:0] quo;

  // Window length of zero acts as one, lengths above the ring size saturate.
  always_comb begin
    if (wlen_r == '0) begin
      len = CNT_W'(1);
    end else if (32'(wlen_r) > DEPTH) begin
      len = CNT_W'(DEPTH);
    end else begin
      len = CNT_W'(wlen_r);
    end
  end

  assign drop = (cnt_r >= len);

  // Oldest slot is write_slot - count, modulo the ring size.
  always_comb begin
    old_tmp = (CNT_W + 1)'(ws_r) + (CNT_W + 1)'(DEPTH) - (CNT_W + 1)'(cnt_r);
    if (old_tmp >= (CNT_W + 1)'(DEPTH)) begin
      old_tmp = old_tmp - (CNT_W + 1)'(DEPTH);
    end
    old_addr = old_tmp[AW-1:0];
  end

  assign sum_nxt = sum_r + SUM_W'(samp_r) - (drop_r ? SUM_W'(rd_r) : '0);
  assign cnt_nxt = drop_r ? cnt_r : cnt_r + CNT_W'(1);
  assign mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign rem_sh = {rem_r, dvd_r[D_W-1]};
  assign ge     = (rem_sh >= {1'b0, cnt_r});
  assign quo    = dvd_r[AVG_W-1:0];

  assign sts.div_last = (step_r == '0);
  assign average      = avg_r;
  assign window_full  = full_out_r;

  // Ring storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring_mem[ws_r] <= samp_r;
    end
    if (cmd.accept) begin
      rd_r <= ring_mem[old_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RST;
      ws_r   <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else if (cfg_we) begin
      wlen_r <= cfg_wlen;
      ws_r   <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else if (cmd.update) begin
      ws_r  <= (32'(ws_r) == DEPTH - 1) ? '0 : ws_r + AW'(1);
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      samp_r <= sample;
      drop_r <= drop;
    end
    if (cmd.update) begin
      full_r <= (cnt_nxt == len);
    end
    if (cmd.load) begin
      neg_r  <= sum_r[SUM_W-1];
      dvd_r  <= {mag, {FRAC_W{1'b0}}};
      rem_r  <= '0;
      step_r <= STEP_W'(D_W - 1);
    end else if (cmd.step) begin
      dvd_r  <= {dvd_r[D_W-2:0], ge};
      rem_r  <= ge ? CNT_W'(rem_sh - {1'b0, cnt_r}) : rem_sh[CNT_W-1:0];
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.finish) begin
      avg_r      <= neg_r ? -quo : quo;
      full_out_r <= full_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= DEPTH)
    else $error("held count above ring size");

  a_cnt_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (cnt_r <= len))
    else $error("held count above window length");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cnt_r != '0))
    else $error("division by an empty window");

endmodule
